>>> src/stldf_pkg.sv
package stldf_pkg;

	localparam int MAX_LINE_LEN_DEF = 64;
	localparam int WIN = 8;
	localparam int ADDR_W = 3;

	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] INV_MASK = 8'hFF;
	localparam logic [7:0] SUM_INIT = INV_MASK ^ START_BYTE;
	localparam logic [15:0] REFRESH_RST = 16'd300;

	// word index of the refresh register (paddr bit 2)
	localparam logic REG_REFRESH = 1'b0;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       sel;
		logic [7:0] ch;
		logic       last;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_EMIT,
		ST_SUM
	} eng_state_t;

endpackage

>>> src/stldf_front.sv
module stldf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // char_code
	input  logic [2:0]          s_tuser,   // command[1:0], line_select[2]
	input  logic                s_tlast,   // last_char
	output logic                op_valid,
	input  logic                op_ready,
	output stldf_pkg::op_t      op
);
	import stldf_pkg::*;

	op_t        ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	op_t        in_op;
	logic       push;
	logic       pop;

	always_comb begin
		in_op.cmd  = cmd_t'(s_tuser[1:0]);
		in_op.sel  = s_tuser[2];
		in_op.ch   = s_tdata;
		in_op.last = s_tlast;
	end

	assign s_tready = (cnt_q != 2'd2);
	// unused command code is taken and dropped here
	assign push     = s_tvalid && s_tready && (in_op.cmd != CMD_NONE);
	assign op_valid = (cnt_q != 2'd0);
	assign op       = ent_q[rp_q];
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> src/stldf_back.sv
module stldf_back #(
	parameter int MAX_LINE_LEN = stldf_pkg::MAX_LINE_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         refresh_time,
	input  logic                op_valid,
	output logic                op_ready,
	input  stldf_pkg::op_t      op,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	import stldf_pkg::*;

	localparam int LEN_W = $clog2(MAX_LINE_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LINE_LEN);
	localparam int SW    = LEN_W + 1;
	localparam int MEM_D = 2 * (1 << IDX_W);

	eng_state_t state_q, state_d;

	logic [LEN_W-1:0] len_q [2];
	logic [LEN_W-1:0] ptr_q [2];
	logic [IDX_W-1:0] pos_q [2];
	logic [15:0]      ms_q;
	logic [3:0]       i_q;
	logic [7:0]       sum_q;

	logic [7:0]       mem [MEM_D];
	logic [7:0]       rd_q;
	logic             use_q;

	logic             ovalid_q;
	logic [7:0]       odata_q;
	logic             olast_q;
	logic             slot_free;

	// load path
	logic [LEN_W-1:0] lp;
	logic [LEN_W-1:0] lp_inc;
	logic             room;
	logic             wr_en;
	logic [IDX_W:0]   wr_addr;

	// tick path
	logic [15:0]      ms_inc;
	logic             fire;

	// window lookup
	logic [LEN_W-1:0] cur_len;
	logic [IDX_W-1:0] cur_pos;
	logic [2:0]       j;
	logic             is_long;
	logic [SW-1:0]    idx_l;
	logic             in_l;
	logic [3:0]       len4;
	logic [3:0]       left4;
	logic [3:0]       j4;
	logic [3:0]       idx_s;
	logic             in_s;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W:0]   rd_addr;
	logic             use_char;
	logic [7:0]       cur_ch;

	logic [IDX_W-1:0] pos_nx [2];

	logic             do_op;
	logic             emit_en;
	logic [7:0]       emit_byte;
	logic             emit_last;

	assign slot_free = !ovalid_q || m_tready;

	// load
	assign lp      = op.sel ? ptr_q[1] : ptr_q[0];
	assign room    = lp < LEN_W'(MAX_LINE_LEN);
	assign lp_inc  = room ? lp + LEN_W'(1) : lp;
	assign wr_en   = do_op && (op.cmd == CMD_LOAD) && room;
	assign wr_addr = {op.sel, lp[IDX_W-1:0]};

	// tick
	assign ms_inc = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
	assign fire   = (ms_inc >= refresh_time) &&
		((len_q[0] != '0) || (len_q[1] != '0));

	// window character lookup for position i_q
	assign cur_len = i_q[3] ? len_q[1] : len_q[0];
	assign cur_pos = i_q[3] ? pos_q[1] : pos_q[0];
	assign j       = i_q[2:0];
	assign is_long = cur_len > LEN_W'(WIN);
	assign idx_l   = SW'(cur_pos) + SW'(j);
	assign in_l    = idx_l < SW'(cur_len);
	// short line: centred, odd spare space on the left
	assign len4    = cur_len[3:0];
	assign left4   = ((4'd8 - len4) >> 1) + {3'b000, len4[0]};
	assign j4      = {1'b0, j};
	assign in_s    = (j4 >= left4) && (j4 < left4 + len4);
	assign idx_s   = j4 - left4;
	assign rd_idx  = is_long ? idx_l[IDX_W-1:0] : IDX_W'(idx_s);
	assign rd_addr = {i_q[3], rd_idx};
	assign use_char = is_long ? in_l : in_s;
	assign cur_ch  = use_q ? rd_q : SPACE_CHAR;

	// scroll advance after a frame
	always_comb begin
		for (int n = 0; n < 2; n++) begin
			if ((len_q[n] > LEN_W'(WIN)) &&
				(SW'(pos_q[n]) < SW'(len_q[n]) - SW'(WIN))) begin
				pos_nx[n] = pos_q[n] + IDX_W'(1);
			end else begin
				pos_nx[n] = '0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		op_ready  = 1'b0;
		do_op     = 1'b0;
		emit_en   = 1'b0;
		emit_byte = START_BYTE;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				op_ready = 1'b1;
				if (op_valid) begin
					do_op = 1'b1;
					if ((op.cmd == CMD_TICK) && fire) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (slot_free) begin
					emit_en = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_byte = cur_ch ^ INV_MASK;
				if (slot_free) begin
					emit_en = 1'b1;
					state_d = (i_q == 4'd15) ? ST_SUM : ST_READ;
				end
			end
			ST_SUM: begin
				emit_byte = sum_q;
				emit_last = 1'b1;
				if (slot_free) begin
					emit_en = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= op.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q  <= mem[rd_addr];
			use_q <= use_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 2; n++) begin
				len_q[n] <= '0;
				ptr_q[n] <= '0;
				pos_q[n] <= '0;
			end
			ms_q  <= '0;
			i_q   <= '0;
			sum_q <= SUM_INIT;
		end else begin
			if (do_op) begin
				case (op.cmd)
					CMD_LOAD: begin
						if (op.last) begin
							len_q[op.sel] <= lp_inc;
							ptr_q[op.sel] <= '0;
						end else begin
							ptr_q[op.sel] <= lp_inc;
						end
					end
					CMD_CLEAR: begin
						len_q[op.sel] <= '0;
						ptr_q[op.sel] <= '0;
						pos_q[op.sel] <= '0;
					end
					CMD_TICK: begin
						ms_q <= fire ? 16'd0 : ms_inc;
					end
					default: begin
					end
				endcase
			end
			if ((state_q == ST_START) && slot_free) begin
				i_q   <= '0;
				sum_q <= SUM_INIT;
			end
			if ((state_q == ST_EMIT) && slot_free) begin
				i_q   <= i_q + 4'd1;
				sum_q <= sum_q + cur_ch;
			end
			if ((state_q == ST_SUM) && slot_free) begin
				pos_q[0] <= pos_nx[0];
				pos_q[1] <= pos_nx[1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_en) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			odata_q <= emit_byte;
			olast_q <= emit_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tlast  = olast_q;

endmodule

>>> src/scrolling_two_line_display_framer.sv
// Two-line text display framer. Items on the input stream load a character
// into the upper or lower line, clear a line, or mark one millisecond tick;
// a tick that brings the count to refresh_time while some line holds text
// starts an 18-byte frame on the output stream (start byte, sixteen inverted
// window characters, checksum flagged by tlast). Input items go through a
// two-entry queue at one per cycle while it has room, so the input keeps
// taking up to two items while a frame is being sent. The frame engine
// handles one queued item at a time; a tick that starts a frame holds the
// engine, and longer under output stall, through the tick itself, the start
// byte, a registered read and an emit for each of the sixteen characters,
// then the checksum byte. refresh_time is at APB address 0 and resets to 300.
module scrolling_two_line_display_framer #(
	parameter int MAX_LINE_LEN = stldf_pkg::MAX_LINE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // char_code
	input  logic [2:0]                    s_tuser,   // command[1:0], line_select[2]
	input  logic                          s_tlast,   // last_char
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // frame_byte
	output logic                          m_tlast,   // frame_last
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [stldf_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import stldf_pkg::*;

	logic [15:0] refresh_q;
	logic        op_valid;
	logic        op_ready;
	op_t         op;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_REFRESH) ? {16'b0, refresh_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= REFRESH_RST;
		end else if (psel && penable && pwrite && pready &&
			(paddr[ADDR_W-1] == REG_REFRESH)) begin
			refresh_q <= pwdata[15:0];
		end
	end

	stldf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	stldf_back #(
		.MAX_LINE_LEN (MAX_LINE_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.refresh_time (refresh_q),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.op           (op),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

>>> verif/scrolling_two_line_display_framer_tb.sv
module scrolling_two_line_display_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stldf_pkg::*;

	localparam int LINE_MAX = MAX_LINE_LEN_DEF;
	localparam logic [ADDR_W-1:0] REFRESH_ADDR = {REG_REFRESH, 2'b00};

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} beat_t;

	// one directed step: the item and whether it should start a frame
	typedef struct packed {
		cmd_t       cmd;
		logic       sel;
		logic [7:0] ch;
		logic       last;
		logic       frame;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the display state
	logic [7:0]  line_chars [2][LINE_MAX];
	int unsigned line_len [2];
	int unsigned load_ptr [2];
	int unsigned scroll_pos [2];
	logic [15:0] tick_count;
	logic [15:0] refresh_ms;

	beat_t       frame_q [$];
	int          errs = 0;
	bit          in_calm = 1'b0;

	int hold_cnt = 0;
	int calm_cnt = 0;
	int stall_pick;

	scrolling_two_line_display_framer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what, input int unsigned expv, input int unsigned gotv);
		errs++;
		if (errs <= 10) begin
			$display("mismatch %s: expected %0h got %0h", what, expv, gotv);
		end
	endtask

	// Updates the shadow state for one accepted item and queues the frame it
	// causes; returns the number of bytes queued.
	function automatic int frame_for_item(op_t it);
		int unsigned p;
		int unsigned ln;
		int unsigned pos;
		int unsigned idx;
		int unsigned left;
		logic [7:0]  win [2*WIN];
		logic [7:0]  sum;
		int          ls;
		ls = int'(it.sel);
		case (it.cmd)
			CMD_LOAD: begin
				p = load_ptr[ls];
				// characters past the end of the store are dropped
				if (p < LINE_MAX) begin
					line_chars[ls][p] = it.ch;
					p++;
				end
				if (it.last) begin
					line_len[ls] = p;
					load_ptr[ls] = 0;
				end else begin
					load_ptr[ls] = p;
				end
				return 0;
			end
			CMD_CLEAR: begin
				line_len[ls] = 0;
				load_ptr[ls] = 0;
				scroll_pos[ls] = 0;
				return 0;
			end
			CMD_TICK: begin
				if (tick_count != 16'hFFFF) tick_count++;
				if (tick_count < refresh_ms) return 0;
				if (line_len[0] == 0 && line_len[1] == 0) return 0;
				for (int n = 0; n < 2; n++) begin
					ln = line_len[n];
					for (int i = 0; i < WIN; i++) win[n*WIN+i] = SPACE_CHAR;
					if (ln > WIN) begin
						pos = scroll_pos[n];
						// a line that shrank shows spaces past its end
						for (int i = 0; i < WIN; i++) begin
							idx = pos + i;
							if (idx < ln && idx < LINE_MAX) win[n*WIN+i] = line_chars[n][idx];
						end
						scroll_pos[n] = (pos < ln - WIN) ? pos + 1 : 0;
					end else begin
						// odd length: the spare space goes left
						left = (WIN - ln) / 2 + (ln & 1);
						scroll_pos[n] = 0;
						for (int i = 0; i < ln; i++) win[n*WIN+left+i] = line_chars[n][i];
					end
				end
				frame_q.push_back('{data: START_BYTE, tail: 1'b0});
				sum = SUM_INIT;
				for (int i = 0; i < 2*WIN; i++) begin
					frame_q.push_back('{data: INV_MASK ^ win[i], tail: 1'b0});
					sum = sum + win[i];
				end
				frame_q.push_back('{data: sum, tail: 1'b1});
				tick_count = '0;
				return 2*WIN + 2;
			end
			default: return 0;
		endcase
	endfunction

	function automatic int idle_gap();
		int r;
		if (in_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_op(input op_t it, output int n_bytes);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.ch;
		s_tuser <= {it.sel, it.cmd};
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		n_bytes = frame_for_item(it);
	endtask

	task automatic send_rand(input cmd_t cmd, input logic sel, input logic last);
		op_t it;
		int  n;
		it.cmd = cmd;
		it.sel = sel;
		it.ch = 8'($urandom);
		it.last = last;
		send_op(it, n);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REFRESH_ADDR) refresh_ms = val;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report("refresh readback", want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// frames drained, then room for queued items that send nothing
	task automatic wait_quiet();
		while (frame_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic run_random(input int n_items);
		int   done;
		int   ln;
		int   nt;
		int   r;
		logic sel;
		done = 0;
		while (done < n_items) begin
			in_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// whole line, then enough ticks to show it a few times
				sel = 1'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					send_rand(CMD_CLEAR, sel, 1'($urandom));
					done++;
				end
				r = $urandom_range(0, 9);
				if (r < 5) ln = $urandom_range(1, WIN);
				else if (r < 9) ln = $urandom_range(WIN + 1, 20);
				else ln = $urandom_range(LINE_MAX - 8, LINE_MAX + 6);
				for (int k = 0; k < ln; k++) send_rand(CMD_LOAD, sel, k == ln - 1);
				nt = $urandom_range(1, 4) * (int'(refresh_ms) + 1);
				for (int k = 0; k < nt; k++) send_rand(CMD_TICK, 1'($urandom), 1'($urandom));
				done += ln + nt;
			end else begin
				// stray item: partial loads, clears, ticks, unused command
				send_rand(cmd_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
				done++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	function automatic step_row_t row(cmd_t cmd, logic sel, logic [7:0] ch, logic last,
			logic frame);
		step_row_t r;
		r.cmd = cmd;
		r.sel = sel;
		r.ch = ch;
		r.last = last;
		r.frame = frame;
		return r;
	endfunction

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (calm_cnt > 0) begin
			calm_cnt <= calm_cnt - 1;
			m_tready <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 8) begin
				calm_cnt <= $urandom_range(20, 200);
				m_tready <= 1'b1;
			end else if (stall_pick < 65) begin
				m_tready <= 1'b1;
			end else if (stall_pick < 95) begin
				hold_cnt <= $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				hold_cnt <= $urandom_range(10, 60);
				m_tready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				report("frame byte with nothing pending", 0, m_tdata);
			end else begin
				want = frame_q.pop_front();
				if (m_tdata !== want.data) report("frame_byte", want.data, m_tdata);
				if (m_tlast !== want.tail) report("frame_last", want.tail, m_tlast);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		step_row_t dir_rows [24];
		logic [15:0] phase_refresh [3];
		op_t it;
		int  n;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < LINE_MAX; i++) line_chars[s][i] = '0;
			line_len[s] = 0;
			load_ptr[s] = 0;
			scroll_pos[s] = 0;
		end
		tick_count = '0;
		refresh_ms = REFRESH_RST;

		dir_rows = '{
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0),   // both lines empty
			row(CMD_NONE,  1'b1, 8'hFF, 1'b1, 1'b0),   // unused command
			row(CMD_LOAD,  1'b0, 8'h41, 1'b1, 1'b0),
			row(CMD_TICK,  1'b1, 8'hFF, 1'b1, 1'b1),
			row(CMD_LOAD,  1'b1, 8'h00, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'hFF, 1'b1, 1'b0),
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b1),
			row(CMD_LOAD,  1'b1, 8'h30, 1'b0, 1'b0),   // nine chars: scrolls
			row(CMD_LOAD,  1'b1, 8'h31, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h32, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h33, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h34, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h35, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h36, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h37, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b1, 8'h80, 1'b1, 1'b0),
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b1),
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b1),   // last window, wraps
			row(CMD_CLEAR, 1'b0, 8'h00, 1'b0, 1'b0),
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b1),
			row(CMD_CLEAR, 1'b1, 8'hFF, 1'b1, 1'b0),
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0),
			row(CMD_LOAD,  1'b0, 8'h20, 1'b0, 1'b0),   // length not yet committed
			row(CMD_TICK,  1'b0, 8'h00, 1'b0, 1'b0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_check(REFRESH_ADDR, {16'h0, REFRESH_RST});
		reg_write(REFRESH_ADDR, 16'd0);
		reg_check(REFRESH_ADDR, 32'd0);

		foreach (dir_rows[k]) begin
			in_calm = ($urandom_range(0, 1) == 0);
			it.cmd = dir_rows[k].cmd;
			it.sel = dir_rows[k].sel;
			it.ch = dir_rows[k].ch;
			it.last = dir_rows[k].last;
			send_op(it, n);
			if ((n != 0) != dir_rows[k].frame) report("frame started", dir_rows[k].frame, n != 0);
		end
		s_tvalid <= 1'b0;
		wait_quiet();

		phase_refresh[0] = 16'd1;
		phase_refresh[1] = 16'($urandom_range(2, 6));
		phase_refresh[2] = 16'd0;
		foreach (phase_refresh[p]) begin
			reg_write(REFRESH_ADDR, phase_refresh[p]);
			reg_check(REFRESH_ADDR, {16'h0, phase_refresh[p]});
			run_random(100);
			wait_quiet();
		end

		// largest refresh: a few ticks with text send nothing
		reg_write(REFRESH_ADDR, 16'hFFFF);
		reg_check(REFRESH_ADDR, 32'h0000_FFFF);
		in_calm = 1'b1;
		send_rand(CMD_CLEAR, 1'b0, 1'b0);
		send_rand(CMD_CLEAR, 1'b1, 1'b1);
		send_rand(CMD_LOAD, 1'($urandom), 1'b1);
		for (int k = 0; k < 4; k++) send_rand(CMD_TICK, 1'($urandom), 1'($urandom));
		s_tvalid <= 1'b0;
		wait_quiet();

		if (errs == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
